/* sv/nmt_pkg.sv */
// Shared types and constants for the NAT mapping table.
package nmt_pkg;

  localparam logic [1:0] OP_LOOKUP_IN  = 2'd0;
  localparam logic [1:0] OP_LOOKUP_OUT = 2'd1;
  localparam logic [1:0] OP_INSERT     = 2'd2;

  localparam logic [15:0] PORT_FIRST = 16'd1024;
  localparam logic [15:0] PORT_LAST  = 16'd65535;
  localparam logic [15:0] QID_FIRST  = 16'd0;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] inside_addr;
    logic [15:0] inside_id;
    logic [15:0] outside_id;
    logic        kind;
    logic [31:0] now;
  } nmt_in_t;

  typedef struct packed {
    logic        hit;
    logic        created;
    logic        table_full;
    logic [31:0] found_inside_addr;
    logic [15:0] found_inside_id;
    logic [15:0] found_outside_id;
    logic        found_kind;
    logic [31:0] found_stamp;
  } nmt_out_t;

  typedef struct packed {
    logic [31:0] inside_addr;
    logic [15:0] inside_id;
    logic [15:0] outside_id;
    logic        kind;
    logic [31:0] stamp;
  } nmt_entry_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic fin_hit;
    logic fin_miss;
  } nmt_cmd_t;

  typedef struct packed {
    logic match;
    logic miss;
  } nmt_sts_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } nmt_state_t;

endpackage

/* sv/nmt_ctrl.sv */
// Controller state machine that sequences the newest-first table scan.
module nmt_ctrl
  import nmt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  nmt_sts_t sts,
  output nmt_cmd_t cmd,
  output logic     busy
);

  nmt_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        busy = 1'b1;
        if (sts.match) begin
          cmd.fin_hit = 1'b1;
          state_nxt   = ST_IDLE;
        end else if (sts.miss) begin
          cmd.fin_miss = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* sv/nmt_datapath.sv */
// Datapath with the mapping memory, scan pointer, id counters and result register.
module nmt_datapath
  import nmt_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64
)
(
  input  logic     clk,
  input  logic     rst_n,
  input  nmt_cmd_t cmd,
  input  nmt_in_t  in_item,
  output nmt_sts_t sts,
  output logic     out_valid,
  output nmt_out_t out_item
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  nmt_entry_t mem [TABLE_ENTRIES];

  nmt_in_t          req_r, req_nxt;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [15:0]      qid_r, qid_nxt;
  logic [15:0]      port_r, port_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0] rd_slot_r;
  nmt_entry_t       rd_data_r;
  logic             out_valid_r, out_valid_nxt;
  nmt_out_t         out_r, out_nxt;

  logic [CNT_W-1:0] ptr_m1;
  logic [IDX_W-1:0] rd_addr;
  logic             rd_en;
  logic             op_valid;
  logic             key_match;
  logic             is_full;
  logic             create;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  nmt_entry_t       wr_data;
  nmt_entry_t       new_ent;
  nmt_entry_t       ref_ent;

  assign op_valid = (in_item.op == OP_LOOKUP_IN) || (in_item.op == OP_LOOKUP_OUT) ||
                    (in_item.op == OP_INSERT);
  assign ptr_m1   = ptr_r - 1'b1;
  assign rd_addr  = ptr_m1[IDX_W-1:0];
  assign rd_en    = cmd.scan && (ptr_r != '0);

  always_comb begin
    key_match = 1'b0;
    if (rd_vld_r && (rd_data_r.kind == req_r.kind)) begin
      if (req_r.op == OP_LOOKUP_OUT) begin
        key_match = (rd_data_r.outside_id == req_r.outside_id);
      end else begin
        key_match = (rd_data_r.inside_addr == req_r.inside_addr) &&
                    (rd_data_r.inside_id == req_r.inside_id);
      end
    end
  end

  assign sts.match = key_match;
  assign sts.miss  = (ptr_r == '0) && !rd_vld_r;

  assign is_full = (fill_r == CNT_W'(TABLE_ENTRIES));
  assign create  = cmd.fin_miss && (req_r.op == OP_INSERT) && !is_full;

  always_comb begin
    new_ent.inside_addr = req_r.inside_addr;
    new_ent.inside_id   = req_r.inside_id;
    new_ent.outside_id  = req_r.kind ? port_r : qid_r;
    new_ent.kind        = req_r.kind;
    new_ent.stamp       = req_r.now;
    ref_ent             = rd_data_r;
    if (req_r.op == OP_INSERT) begin
      ref_ent.stamp = req_r.now;
    end
  end

  assign wr_en   = create || (cmd.fin_hit && (req_r.op == OP_INSERT));
  assign wr_addr = create ? fill_r[IDX_W-1:0] : rd_slot_r;
  assign wr_data = create ? new_ent : ref_ent;

  always_comb begin
    req_nxt       = req_r;
    ptr_nxt       = ptr_r;
    rd_vld_nxt    = rd_en;
    fill_nxt      = fill_r;
    qid_nxt       = qid_r;
    port_nxt      = port_r;
    out_valid_nxt = cmd.fin_hit || cmd.fin_miss;
    out_nxt       = out_r;
    if (cmd.load) begin
      req_nxt    = in_item;
      ptr_nxt    = op_valid ? fill_r : '0;
      rd_vld_nxt = 1'b0;
    end
    if (rd_en) begin
      ptr_nxt = ptr_m1;
    end
    if (cmd.fin_hit) begin
      out_nxt                   = '0;
      out_nxt.hit               = 1'b1;
      out_nxt.found_inside_addr = ref_ent.inside_addr;
      out_nxt.found_inside_id   = ref_ent.inside_id;
      out_nxt.found_outside_id  = ref_ent.outside_id;
      out_nxt.found_kind        = ref_ent.kind;
      out_nxt.found_stamp       = ref_ent.stamp;
    end
    if (cmd.fin_miss) begin
      out_nxt = '0;
      if (req_r.op == OP_INSERT) begin
        if (is_full) begin
          out_nxt.table_full = 1'b1;
        end else begin
          out_nxt.hit               = 1'b1;
          out_nxt.created           = 1'b1;
          out_nxt.found_inside_addr = new_ent.inside_addr;
          out_nxt.found_inside_id   = new_ent.inside_id;
          out_nxt.found_outside_id  = new_ent.outside_id;
          out_nxt.found_kind        = new_ent.kind;
          out_nxt.found_stamp       = new_ent.stamp;
        end
      end
    end
    if (create) begin
      fill_nxt = fill_r + 1'b1;
      if (req_r.kind) begin
        port_nxt = (port_r == PORT_LAST) ? PORT_FIRST : port_r + 16'd1;
      end else begin
        qid_nxt = qid_r + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r       <= '0;
      rd_vld_r    <= 1'b0;
      fill_r      <= '0;
      qid_r       <= QID_FIRST;
      port_r      <= PORT_FIRST;
      out_valid_r <= 1'b0;
    end else begin
      ptr_r       <= ptr_nxt;
      rd_vld_r    <= rd_vld_nxt;
      fill_r      <= fill_nxt;
      qid_r       <= qid_nxt;
      port_r      <= port_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    out_r <= out_nxt;
    if (rd_en) begin
      rd_slot_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

/* sv/nat_mapping_table.sv */
// Top level of the NAT mapping table: controller plus datapath.
// A transaction scans the stored entries newest first and ends at the newest match,
// or after the oldest entry when nothing matches; busy drops in the cycle the result
// strobe is shown. Only one transaction is in flight at a time: a new one is accepted
// only while busy is low, and the single read port of the entry memory is scanned one
// entry per cycle.
// Reset: synchronous rst_n empties the table and restarts both id counters.
module nat_mapping_table
  import nmt_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64
)
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  nmt_in_t  in_item,
  output logic     out_valid,
  output nmt_out_t out_item
);

  nmt_cmd_t cmd;
  nmt_sts_t sts;

  nmt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  nmt_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_item),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

/* sv/nmt_checker.sv */
// Port-level checker for the NAT mapping table and its bind statement.
module nmt_checker
  import nmt_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_valid,
  input nmt_out_t out_item
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted transaction");

  a_result_when_done: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("transaction finished without a result strobe");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.hit) |->
      (out_item.found_inside_addr == '0) && (out_item.found_inside_id == '0) &&
      (out_item.found_outside_id == '0) && !out_item.found_kind &&
      (out_item.found_stamp == '0) && !out_item.created)
    else $error("miss result carries mapping fields");

  a_created_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.created) |-> (out_item.hit && !out_item.table_full))
    else $error("created result without hit or with table_full");

endmodule

bind nat_mapping_table nmt_checker u_nmt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);
